FILE: src/lru_key_value_cache_top_defines.svh
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// checked only outside reset
`define LKVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lkvc_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, command and state codes, and the cell control bundle.
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CFG_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;  // latch key compare result
    logic update;   // apply recency shift
    logic hit;      // some live entry matched
  } cell_ctl_t;

endpackage

FILE: src/lkvc_cell.sv
// ---------------------------------------------------------------------------
// LRU cache cell
// One recency slot: holds a key and value, compares against the lookup key,
// and takes its upstream neighbor's entry when the promote shift reaches it.
// ---------------------------------------------------------------------------
module lkvc_cell (
  input  logic                     clk,
  input  lkvc_pkg::cell_ctl_t      ctl,
  input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
  input  logic                     live,
  input  logic                     prev_live,
  input  logic [lkvc_pkg::KEY_W-1:0] up_key,
  input  logic [lkvc_pkg::VAL_W-1:0] up_value,
  output logic [lkvc_pkg::KEY_W-1:0] entry_key,
  output logic [lkvc_pkg::VAL_W-1:0] entry_value,
  input  logic                     sel_in,
  output logic                     sel_out,
  input  logic [lkvc_pkg::VAL_W-1:0] rd_in,
  output logic [lkvc_pkg::VAL_W-1:0] rd_out
);
  import lkvc_pkg::*;

  logic hit_here;
  logic shift;

  // sel_out: this slot or one below it matched, so the shift covers this slot
  assign sel_out = hit_here | sel_in;
  assign rd_out  = rd_in | (hit_here ? entry_value : '0);
  // hit: shift slots up to the match; new key: shift slots up to the fill level
  assign shift   = ctl.update & (ctl.hit ? sel_out : prev_live);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit_here <= live && (lookup_key == entry_key);
    end
    if (shift) begin
      entry_key   <= up_key;
      entry_value <= up_value;
    end
  end

endmodule

FILE: src/lru_key_value_cache_top.sv
// ---------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Per item: on the accept edge every slot of the cell chain compares its key
// with the incoming key; in ST_UPDATE the recency shift is applied and the
// result is loaded into the output register. The next item is taken once the
// state is back in ST_IDLE. If the output register still holds an untaken
// result, the update waits for it. capacity_in_use limits how many entries
// are held (0 acts as 1, values above the slot count saturate).
module lru_key_value_cache_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,  // key[31:0], value[63:32]
  input  logic                            s_tuser,  // command (0 get, 1 put)
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,  // read_value[31:0]
  output logic                            m_tuser,  // hit
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lkvc_pkg::CFG_W-1:0]      cfg_data  // capacity_in_use
);
  import lkvc_pkg::*;

  state_t             state, state_next;
  logic               upd;
  cmd_t               item_cmd;
  logic [KEY_W-1:0]   item_key;
  logic [VAL_W-1:0]   item_value;
  logic [CNT_W-1:0]   count, count_next;
  logic [CFG_W-1:0]   capacity_in_use;
  logic [CMP_W-1:0]   cap_eff, grown, cfg_wide;
  cell_ctl_t          ctl;
  logic               hit;
  logic [VAL_W-1:0]   rd_value;
  logic [VAL_W-1:0]   new_value;

  logic [KEY_W-1:0]   cell_key   [CAPACITY];
  logic [VAL_W-1:0]   cell_value [CAPACITY];
  logic [CAPACITY:0]  sel_chain;
  logic [VAL_W-1:0]   rd_chain   [CAPACITY+1];
  logic [CAPACITY-1:0] live;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CFG_RESET;
    end else if (cfg_valid) begin
      capacity_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    upd        = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          upd        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_cmd   <= cmd_t'(s_tuser);
      item_key   <= s_tdata[KEY_W-1:0];
      item_value <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  assign hit         = sel_chain[0];
  assign rd_value    = rd_chain[0];
  assign new_value   = (item_cmd == CMD_PUT) ? item_value : rd_value;
  assign ctl.capture = s_tvalid & s_tready;
  assign ctl.update  = upd & (hit | (item_cmd == CMD_PUT));
  assign ctl.hit     = hit;

  assign sel_chain[CAPACITY] = 1'b0;
  assign rd_chain[CAPACITY]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] up_key;
    logic [VAL_W-1:0] up_value;
    logic             prev_live;

    assign live[i] = count > CNT_W'(i);

    if (i == 0) begin : g_head
      assign up_key    = item_key;
      assign up_value  = new_value;
      assign prev_live = 1'b1;
    end else begin : g_body
      assign up_key    = cell_key[i-1];
      assign up_value  = cell_value[i-1];
      assign prev_live = live[i-1];
    end

    lkvc_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .lookup_key  (s_tdata[KEY_W-1:0]),
      .live        (live[i]),
      .prev_live   (prev_live),
      .up_key      (up_key),
      .up_value    (up_value),
      .entry_key   (cell_key[i]),
      .entry_value (cell_value[i]),
      .sel_in      (sel_chain[i+1]),
      .sel_out     (sel_chain[i]),
      .rd_in       (rd_chain[i+1]),
      .rd_out      (rd_chain[i])
    );
  end

  // fill level after inserting a new key, trimmed to the capacity in use
  always_comb begin
    cfg_wide = CMP_W'(capacity_in_use);
    grown    = CMP_W'(count) + CMP_W'(1);
    if (cfg_wide == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cfg_wide > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cfg_wide;
    end
    count_next = (grown > cap_eff) ? CNT_W'(cap_eff) : CNT_W'(grown);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd && (item_cmd == CMD_PUT) && !hit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      m_tuser <= hit;
      m_tdata <= ((item_cmd == CMD_GET) && hit) ? rd_value : '1;
    end
  end

endmodule

FILE: src/lkvc_checker.sv
// ---------------------------------------------------------------------------
// LRU key-value cache port checker
// Port-level properties of the cache, bound to the top level.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  `LKVC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
  `LKVC_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "item accepted while previous one in work")
  `LKVC_ASSERT(a_miss_all_ones, m_tvalid && !m_tuser |-> m_tdata == '1, "miss result not all ones")
  `LKVC_ASSERT_ALWAYS(a_ready_after_rst, rst |=> s_tready && !m_tvalid, "not idle after reset")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

FILE: dv/tb_lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU key-value cache testbench
// Directed table then random get/put traffic over several capacity settings,
// scored against typed row results or an in-bench recency-stack model, with
// random idles on both streams outside one no-idle phase.
// ---------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value;
  } lookup_t;

  typedef struct packed {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  data;   // put value, or capacity on a cfg row
    logic              typed;  // expected result given in the row
    logic              hit;
    logic [VAL_W-1:0]  value;
  } stim_row_t;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 170;
  localparam int POOL_SIZE    = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // key[31:0], value[63:32]
  logic s_tuser = 1'b0;        // command (0 get, 1 put)
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;        // read_value[31:0]
  logic m_tuser;               // hit
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  lru_key_value_cache_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // recency stack model, slot 0 most recent
  logic [KEY_W-1:0] stack_keys [CAPACITY];
  logic [VAL_W-1:0] stack_vals [CAPACITY];
  int               stack_fill = 0;
  logic [CFG_W-1:0] capacity_reg = CFG_RESET;

  lookup_t pending_lookups [$];
  int      errors = 0;
  bit      no_idle = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  function automatic void move_to_front(int pos, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] val);
    for (int i = pos; i > 0; i--) begin
      stack_keys[i] = stack_keys[i-1];
      stack_vals[i] = stack_vals[i-1];
    end
    stack_keys[0] = key;
    stack_vals[0] = val;
  endfunction

  function automatic lookup_t cache_access(cmd_t cmd, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] val);
    lookup_t res;
    int      pos;
    int      n;
    int      cap;
    pos = -1;
    n = stack_fill;
    for (int i = 0; i < n; i++) begin
      if (pos < 0 && stack_keys[i] == key) pos = i;
    end
    res.hit = (pos >= 0);
    res.value = MISS_VALUE;
    if (cmd == CMD_GET) begin
      if (res.hit) begin
        res.value = stack_vals[pos];
        move_to_front(pos, key, res.value);
      end
    end else if (res.hit) begin
      move_to_front(pos, key, val);
    end else begin
      cap = (capacity_reg == 0) ? 1 : (capacity_reg > CAPACITY) ? CAPACITY : capacity_reg;
      move_to_front((n >= CAPACITY) ? CAPACITY - 1 : n, key, val);
      n = n + 1;
      stack_fill = (n > cap) ? cap : n;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    lookup_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lookups.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit=%0b value=%h", $time, m_tuser, m_tdata);
      end else begin
        want = pending_lookups.pop_front();
        if (m_tuser !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch exp=%0b act=%0b", $time, want.hit, m_tuser);
        end
        if (m_tdata !== want.value) begin
          errors++;
          $display("%0t: read_value mismatch exp=%h act=%h", $time, want.value, m_tdata);
        end
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                           bit typed, lookup_t typed_res);
    lookup_t res;
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {val, key};
    do @(posedge clk); while (!s_tready);
    res = cache_access(cmd, key, val);
    pending_lookups.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
  endtask

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // empty cache, then extremes of key and value
    '{ROW_ITEM, CMD_GET, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_PUT, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'h7FFFFFFF},
    '{ROW_ITEM, CMD_PUT, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'h80000000},
    // overwrite of a present key
    '{ROW_ITEM, CMD_PUT, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
    '{ROW_ITEM, CMD_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_PUT, 32'h00000000, 32'h55555555, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h00000000, 32'hAAAAAAAA, 1'b1, 1'b1, 32'h55555555},
    // capacity zero behaves as one
    '{ROW_CFG,  CMD_GET, 32'h00000000, 32'd0,        1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_PUT, 32'h12345678, 32'hA5A5A5A5, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h80000000, 32'h00000000, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h12345678, 32'h00000000, 1'b1, 1'b1, 32'hA5A5A5A5},
    '{ROW_ITEM, CMD_PUT, 32'h0000FFFF, 32'h00000001, 1'b1, 1'b0, 32'hFFFFFFFF},
    '{ROW_ITEM, CMD_GET, 32'h12345678, 32'h00000000, 1'b1, 1'b0, 32'hFFFFFFFF},
    // capacity above slot count saturates
    '{ROW_CFG,  CMD_GET, 32'h00000000, 32'd31,       1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_PUT, 32'hFFFF0000, 32'h00000002, 1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_PUT, 32'h00000001, 32'h00000003, 1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_GET, 32'h0000FFFF, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
    // lowered below occupancy: old entries still hit until the next new put
    '{ROW_CFG,  CMD_GET, 32'h00000000, 32'd2,        1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_GET, 32'hFFFF0000, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_PUT, 32'hDEADBEEF, 32'h00000004, 1'b0, 1'b0, 32'h00000000},
    '{ROW_ITEM, CMD_GET, 32'h00000001, 32'h00000000, 1'b0, 1'b0, 32'h00000000}
  };

  logic [CFG_W-1:0] cap_plan [10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd16,
                                      5'd3, 5'd17, 5'd8, 5'd16, 5'd2};

  initial begin
    lookup_t          row_res;
    logic [KEY_W-1:0] key;
    logic [CFG_W-1:0] cap;
    int               pick;
    int               guard;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_capacity(directed_rows[r].data[CFG_W-1:0]);
      end else begin
        row_res.hit = directed_rows[r].hit;
        row_res.value = directed_rows[r].value;
        send_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].data,
                  directed_rows[r].typed, row_res);
      end
    end

    row_res = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cap = (ph < 10) ? cap_plan[ph] : CFG_W'($urandom_range(0, 31));
      write_capacity(cap);
      no_idle = (ph == 2);
      if (ph == 0 || ph == 6 || ph == 9) begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 80 && stack_fill > 0) key = stack_keys[$urandom_range(0, stack_fill - 1)];
        else key = $urandom;
        send_item(cmd_t'($urandom_range(0, 1)), key, $urandom, 1'b0, row_res);
      end
    end
    no_idle = 1'b0;

    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_lookups.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_lookups.size());
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
